[rtl/rotenc_pkg.sv]
`default_nettype none

package rotenc_pkg;

	localparam int LEVEL_BITS_DEF = 12;
	localparam int TICK_BITS_DEF  = 24;

	localparam int ADDR_BITS     = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam int IN_DATA_BITS  = 8;

	localparam int RESET_STEP     = 25;
	localparam int RESET_MAX      = 1000;
	localparam int RESET_DEFAULT  = 500;
	localparam int RESET_DEBOUNCE = 80000;
	localparam int RESET_LEVEL    = 500;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_STEP     = 2'd0,
		REG_MAX      = 2'd1,
		REG_DEFAULT  = 2'd2,
		REG_DEBOUNCE = 2'd3
	} reg_idx_t;

	// bit positions inside the input tdata
	localparam int IN_BIT_A   = 0;
	localparam int IN_BIT_B   = 1;
	localparam int IN_BIT_BTN = 2;

endpackage

`default_nettype wire

[rtl/rotenc_regs.sv]
`default_nettype none

module rotenc_regs #(
	parameter int LEVEL_BITS = rotenc_pkg::LEVEL_BITS_DEF,
	parameter int TICK_BITS  = rotenc_pkg::TICK_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [rotenc_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [rotenc_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic      [rotenc_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                       pready,
	output logic      [LEVEL_BITS-1:0]                 step_size,
	output logic      [LEVEL_BITS-1:0]                 max_level,
	output logic      [LEVEL_BITS-1:0]                 default_on_level,
	output logic      [TICK_BITS-1:0]                  debounce_ticks
);

	logic [LEVEL_BITS-1:0] step_q;
	logic [LEVEL_BITS-1:0] max_q;
	logic [LEVEL_BITS-1:0] dflt_q;
	logic [TICK_BITS-1:0]  deb_q;
	logic                  wr_en;
	rotenc_pkg::reg_idx_t  idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = rotenc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= LEVEL_BITS'(rotenc_pkg::RESET_STEP);
			max_q  <= LEVEL_BITS'(rotenc_pkg::RESET_MAX);
			dflt_q <= LEVEL_BITS'(rotenc_pkg::RESET_DEFAULT);
			deb_q  <= TICK_BITS'(rotenc_pkg::RESET_DEBOUNCE);
		end else if (wr_en) begin
			unique case (idx)
				rotenc_pkg::REG_STEP:     step_q <= pwdata[LEVEL_BITS-1:0];
				rotenc_pkg::REG_MAX:      max_q  <= pwdata[LEVEL_BITS-1:0];
				rotenc_pkg::REG_DEFAULT:  dflt_q <= pwdata[LEVEL_BITS-1:0];
				rotenc_pkg::REG_DEBOUNCE: deb_q  <= pwdata[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rotenc_pkg::REG_STEP:     prdata = rotenc_pkg::CFG_DATA_BITS'(step_q);
			rotenc_pkg::REG_MAX:      prdata = rotenc_pkg::CFG_DATA_BITS'(max_q);
			rotenc_pkg::REG_DEFAULT:  prdata = rotenc_pkg::CFG_DATA_BITS'(dflt_q);
			rotenc_pkg::REG_DEBOUNCE: prdata = rotenc_pkg::CFG_DATA_BITS'(deb_q);
			default:                  prdata = '0;
		endcase
	end

	assign step_size        = step_q;
	assign max_level        = max_q;
	assign default_on_level = dflt_q;
	assign debounce_ticks   = deb_q;

endmodule

`default_nettype wire

[rtl/rotenc_core.sv]
`default_nettype none

module rotenc_core #(
	parameter int LEVEL_BITS = rotenc_pkg::LEVEL_BITS_DEF,
	parameter int TICK_BITS  = rotenc_pkg::TICK_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [LEVEL_BITS-1:0] step_size,
	input  wire logic [LEVEL_BITS-1:0] max_level,
	input  wire logic [LEVEL_BITS-1:0] default_on_level,
	input  wire logic [TICK_BITS-1:0]  debounce_ticks,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  enc_a,
	input  wire logic                  enc_b,
	input  wire logic                  button_n,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [LEVEL_BITS-1:0] level,
	output logic                       lamp_on
);

	// input stage
	logic v_s1, a_s1, b_s1, btn_s1;
	// state
	logic                  prev_a_q, prev_b_q, on_q;
	logic [TICK_BITS-1:0]  ticks_q;
	logic [LEVEL_BITS-1:0] cur_q, saved_q;
	// result register
	logic                  out_v_q, out_on_q;
	logic [LEVEL_BITS-1:0] out_level_q;

	logic                  advance, fire;
	logic                  up, down, toggle;
	logic [LEVEL_BITS:0]   sum;
	logic [LEVEL_BITS-1:0] enc_level, cur_d, saved_d;
	logic [TICK_BITS-1:0]  ticks_inc, ticks_d;
	logic                  on_d;

	assign advance  = !out_v_q || out_ready;
	assign fire     = v_s1 && advance;
	assign in_ready = !v_s1 || advance;

	assign up   = on_q && !prev_a_q && a_s1 && !b_s1;
	assign down = on_q && !prev_b_q && b_s1 && !a_s1;
	assign sum  = {1'b0, cur_q} + {1'b0, step_size};

	always_comb begin
		enc_level = cur_q;
		if (up) begin
			enc_level = (sum > {1'b0, max_level}) ? max_level : sum[LEVEL_BITS-1:0];
		end else if (down) begin
			enc_level = (step_size > cur_q) ? '0 : cur_q - step_size;
		end
	end

	// counter saturates at all ones
	assign ticks_inc = (&ticks_q) ? ticks_q : ticks_q + TICK_BITS'(1);
	assign toggle    = !btn_s1 && (ticks_inc > debounce_ticks);
	assign ticks_d   = btn_s1 ? ticks_inc : '0;

	always_comb begin
		cur_d   = enc_level;
		saved_d = saved_q;
		on_d    = on_q;
		if (toggle) begin
			// direction follows the level, not the lamp flag
			if (enc_level != '0) begin
				saved_d = enc_level;
				cur_d   = '0;
				on_d    = 1'b0;
			end else begin
				cur_d = (saved_q == '0) ? default_on_level : saved_q;
				on_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_s1   <= enc_a;
			b_s1   <= enc_b;
			btn_s1 <= button_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b1;
			prev_b_q <= 1'b1;
			on_q     <= 1'b1;
			ticks_q  <= '1;
			cur_q    <= LEVEL_BITS'(rotenc_pkg::RESET_LEVEL);
			saved_q  <= LEVEL_BITS'(rotenc_pkg::RESET_LEVEL);
			out_v_q  <= 1'b0;
		end else begin
			if (fire) begin
				prev_a_q <= a_s1;
				prev_b_q <= b_s1;
				on_q     <= on_d;
				ticks_q  <= ticks_d;
				cur_q    <= cur_d;
				saved_q  <= saved_d;
				out_v_q  <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_level_q <= cur_d;
			out_on_q    <= on_d;
		end
	end

	assign out_valid = out_v_q;
	assign level     = out_level_q;
	assign lamp_on   = out_on_q;

`ifndef NO_ASSERTIONS
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!on_q |-> cur_q == '0)
		else $error("lamp off with nonzero level");

	a_out_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_on_q |-> out_level_q == '0)
		else $error("result off with nonzero level");

	a_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !btn_s1 |=> ticks_q == '0)
		else $error("button press did not restart counter");

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_v_q && out_level_q == cur_q && out_on_q == on_q)
		else $error("result does not match state");
`endif

endmodule

`default_nettype wire

[rtl/rotary_encoder_dimmer.sv]
`default_nettype none

// Rotary encoder dimmer. Each item on the s_ stream is one sample of encoder
// pins A, B and the active-low button. Each item yields exactly one result item
// on the m_ stream with the updated level and lamp state. A result passes
// through the input register, then the result register, before it is
// presented on m_tvalid. One item is taken per clock, set by the state update
// between those two registers, as long as m_tready is high. Registers on the
// APB port (0x0 step_size, 0x4 max_level, 0x8 default_on_level, 0xC
// debounce_ticks) are to be written by the user only while the stream is idle;
// the block itself does not enforce this.
module rotary_encoder_dimmer #(
	parameter int LEVEL_BITS = rotenc_pkg::LEVEL_BITS_DEF,
	parameter int TICK_BITS  = rotenc_pkg::TICK_BITS_DEF,
	localparam int OUT_BITS  = ((LEVEL_BITS + 1 + 7) / 8) * 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [rotenc_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [rotenc_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic      [rotenc_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                       pready,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [rotenc_pkg::IN_DATA_BITS-1:0]   s_tdata,  // enc_a, enc_b, button_n
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [OUT_BITS-1:0]                   m_tdata   // level, lamp_on
);

	logic [LEVEL_BITS-1:0] step_size, max_level, default_on_level, level;
	logic [TICK_BITS-1:0]  debounce_ticks;
	logic                  lamp_on;

	rotenc_regs #(
		.LEVEL_BITS(LEVEL_BITS),
		.TICK_BITS (TICK_BITS)
	) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.step_size       (step_size),
		.max_level       (max_level),
		.default_on_level(default_on_level),
		.debounce_ticks  (debounce_ticks)
	);

	rotenc_core #(
		.LEVEL_BITS(LEVEL_BITS),
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_size       (step_size),
		.max_level       (max_level),
		.default_on_level(default_on_level),
		.debounce_ticks  (debounce_ticks),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.enc_a           (s_tdata[rotenc_pkg::IN_BIT_A]),
		.enc_b           (s_tdata[rotenc_pkg::IN_BIT_B]),
		.button_n        (s_tdata[rotenc_pkg::IN_BIT_BTN]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.level           (level),
		.lamp_on         (lamp_on)
	);

	assign m_tdata = OUT_BITS'({lamp_on, level});

endmodule

`default_nettype wire

[tb/dimmer_checker.sv]
`timescale 1ns / 1ps

module dimmer_checker #(
	parameter int LEVEL_BITS = rotenc_pkg::LEVEL_BITS_DEF,
	parameter int TICK_BITS  = rotenc_pkg::TICK_BITS_DEF,
	parameter int OUT_BITS   = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic                                  pready,
	input  wire logic [rotenc_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [rotenc_pkg::CFG_DATA_BITS-1:0]  pwdata,
	input  wire logic                                  s_tvalid,
	input  wire logic                                  s_tready,
	input  wire logic [rotenc_pkg::IN_DATA_BITS-1:0]   s_tdata,  // enc_a, enc_b, button_n
	input  wire logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	input  wire logic [OUT_BITS-1:0]                   m_tdata,  // level, lamp_on
	output int                                         errors,
	output int                                         queued,
	output int                                         matched,
	output int                                         toggles,
	output int                                         detents
);

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  lamp_on;
	} lamp_out_t;

	lamp_out_t lamp_q[$];

	logic [LEVEL_BITS-1:0] step_cfg;
	logic [LEVEL_BITS-1:0] max_cfg;
	logic [LEVEL_BITS-1:0] dflt_cfg;
	logic [TICK_BITS-1:0]  debounce_cfg;

	logic                  last_a;
	logic                  last_b;
	logic [TICK_BITS-1:0]  since_low;
	logic [LEVEL_BITS-1:0] level_now;
	logic [LEVEL_BITS-1:0] level_saved;
	logic                  lamp;

	// Advance the dimmer by one pin sample and queue the level it shows afterwards.
	function automatic void dimmer_tick(input logic a, input logic b, input logic btn);
		logic [LEVEL_BITS:0] sum;
		lamp_out_t           r;
		sum = {1'b0, level_now} + step_cfg;
		// encoder sees the lamp state from before this sample's button
		if (lamp) begin
			if (!last_a && a && !b) begin
				level_now = (sum > max_cfg) ? max_cfg : sum[LEVEL_BITS-1:0];
				detents++;
			end else if (!last_b && b && !a) begin
				level_now = (step_cfg > level_now) ? '0 : level_now - step_cfg;
				detents++;
			end
		end
		if (since_low != '1)
			since_low++;
		if (!btn) begin
			// direction follows the level, not the lamp flag
			if (since_low > debounce_cfg) begin
				toggles++;
				if (level_now != '0) begin
					level_saved = level_now;
					level_now   = '0;
					lamp        = 1'b0;
				end else begin
					level_now = (level_saved == '0) ? dflt_cfg : level_saved;
					lamp      = 1'b1;
				end
			end
			since_low = '0;
		end
		last_a    = a;
		last_b    = b;
		r.level   = level_now;
		r.lamp_on = lamp;
		lamp_q.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lamp_out_t             want;
		logic [LEVEL_BITS-1:0] got_level;
		logic                  got_lamp;
		if (!arst_n) begin
			lamp_q.delete();
			step_cfg     = LEVEL_BITS'(rotenc_pkg::RESET_STEP);
			max_cfg      = LEVEL_BITS'(rotenc_pkg::RESET_MAX);
			dflt_cfg     = LEVEL_BITS'(rotenc_pkg::RESET_DEFAULT);
			debounce_cfg = TICK_BITS'(rotenc_pkg::RESET_DEBOUNCE);
			last_a       = 1'b1;
			last_b       = 1'b1;
			since_low    = '1;
			level_now    = LEVEL_BITS'(rotenc_pkg::RESET_LEVEL);
			level_saved  = LEVEL_BITS'(rotenc_pkg::RESET_LEVEL);
			lamp         = 1'b1;
			errors       = 0;
			queued       = 0;
			matched      = 0;
			toggles      = 0;
			detents      = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					rotenc_pkg::REG_STEP:     step_cfg = pwdata[LEVEL_BITS-1:0];
					rotenc_pkg::REG_MAX:      max_cfg = pwdata[LEVEL_BITS-1:0];
					rotenc_pkg::REG_DEFAULT:  dflt_cfg = pwdata[LEVEL_BITS-1:0];
					rotenc_pkg::REG_DEBOUNCE: debounce_cfg = pwdata[TICK_BITS-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_level = m_tdata[LEVEL_BITS-1:0];
				got_lamp  = m_tdata[LEVEL_BITS];
				if (lamp_q.size() == 0) begin
					errors++;
					$display("%0t: result level=%0d lamp_on=%0b with no item pending",
						$time, got_level, got_lamp);
				end else begin
					want = lamp_q.pop_front();
					if (got_level != want.level) begin
						errors++;
						$display("%0t: level expected %0d, actual %0d",
							$time, want.level, got_level);
					end
					if (got_lamp != want.lamp_on) begin
						errors++;
						$display("%0t: lamp_on expected %0b, actual %0b",
							$time, want.lamp_on, got_lamp);
					end
					if (got_level == want.level && got_lamp == want.lamp_on)
						matched++;
				end
			end
			if (s_tvalid && s_tready)
				dimmer_tick(s_tdata[rotenc_pkg::IN_BIT_A], s_tdata[rotenc_pkg::IN_BIT_B],
					s_tdata[rotenc_pkg::IN_BIT_BTN]);
			queued = lamp_q.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int LEVEL_BITS = rotenc_pkg::LEVEL_BITS_DEF;
	localparam int TICK_BITS  = rotenc_pkg::TICK_BITS_DEF;
	localparam int OUT_BITS   = ((LEVEL_BITS + 1 + 7) / 8) * 8;
	localparam int PHASE_ITEMS = 255;
	// quadrature walk, {a, b} per position; stepping forward is an up detent
	localparam logic [7:0] QUAD_SEQ = 8'b01_11_10_00;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  psel = 1'b0;
	logic                                  penable = 1'b0;
	logic                                  pwrite = 1'b0;
	logic [rotenc_pkg::ADDR_BITS-1:0]      paddr = '0;
	logic [rotenc_pkg::CFG_DATA_BITS-1:0]  pwdata = '0;
	logic [rotenc_pkg::CFG_DATA_BITS-1:0]  prdata;
	logic                                  pready;
	logic                                  s_tvalid = 1'b0;
	logic                                  s_tready;
	logic [rotenc_pkg::IN_DATA_BITS-1:0]   s_tdata = '0;  // enc_a, enc_b, button_n
	logic                                  m_tvalid;
	logic                                  m_tready = 1'b0;
	logic [OUT_BITS-1:0]                   m_tdata;       // level, lamp_on

	int   errors, queued, matched, toggles, detents;
	int   sent = 0;
	int   settings = 0;
	logic send_fast = 1'b0;

	always #4 clk = ~clk;

	rotary_encoder_dimmer u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	dimmer_checker #(.LEVEL_BITS(LEVEL_BITS), .TICK_BITS(TICK_BITS), .OUT_BITS(OUT_BITS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .queued(queued), .matched(matched),
		.toggles(toggles), .detents(detents)
	);

	task automatic send_pins(input logic a, input logic b, input logic btn);
		int                                  gap;
		logic [rotenc_pkg::IN_DATA_BITS-1:0] d;
		gap = send_fast ? 0 : $urandom_range(0, 7);
		d = '0;
		d[rotenc_pkg::IN_BIT_A]   = a;
		d[rotenc_pkg::IN_BIT_B]   = b;
		d[rotenc_pkg::IN_BIT_BTN] = btn;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Drop valid and hold until every pending result has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (queued == 0);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input rotenc_pkg::reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Upper bits carry junk; the block keeps only the register width.
	task automatic configure(input int step, input int maxl, input int dflt, input int deb);
		wait_idle();
		write_reg(rotenc_pkg::REG_STEP, ($urandom << LEVEL_BITS) | 32'(step));
		write_reg(rotenc_pkg::REG_MAX, ($urandom << LEVEL_BITS) | 32'(maxl));
		write_reg(rotenc_pkg::REG_DEFAULT, ($urandom << LEVEL_BITS) | 32'(dflt));
		write_reg(rotenc_pkg::REG_DEBOUNCE, ($urandom << TICK_BITS) | 32'(deb));
		settings++;
	endtask

	task automatic run_phase(input int count, input logic fast, input int pause_at);
		int   q, lows, r;
		logic dir, a, b, btn;
		q = 0;
		lows = 0;
		dir = 1'($urandom);
		send_fast = fast;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if ($urandom_range(0, 15) == 0)
					dir = ~dir;
				if ($urandom_range(0, 3) != 0)
					q = dir ? (q + 1) % 4 : (q + 3) % 4;
				a = QUAD_SEQ[2*q+1];
				b = QUAD_SEQ[2*q];
			end else begin
				a = 1'($urandom);
				b = 1'($urandom);
			end
			// presses come in short bursts of low samples
			if (lows > 0) begin
				btn = 1'b0;
				lows--;
			end else if ($urandom_range(0, 11) == 0) begin
				btn = 1'b0;
				lows = $urandom_range(0, 2);
			end else begin
				btn = 1'b1;
			end
			send_pins(a, b, btn);
		end
		send_fast = 1'b0;
	endtask

	initial begin : sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = ((taken / 128) % 3 == 1) ? 0 : $urandom_range(0, 7);
			// long hold so the block backs up into its input
			if (taken == 700)
				gap = 120;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: detents, ignored edges, toggle off, debounce hold
		send_pins(0, 0, 1);
		send_pins(1, 0, 1);
		send_pins(0, 0, 1);
		send_pins(0, 1, 1);
		send_pins(1, 1, 1);
		send_pins(0, 0, 1);
		send_pins(1, 1, 1);
		send_pins(0, 0, 0);
		send_pins(1, 0, 1);
		send_pins(0, 0, 0);

		// full-scale step, no debounce: saturate both ways, toggle at level zero
		configure(4095, 4095, 0, 0);
		send_pins(0, 0, 0);
		send_pins(1, 0, 1);
		send_pins(0, 0, 1);
		send_pins(0, 1, 1);
		send_pins(0, 1, 0);
		send_pins(0, 0, 0);
		send_pins(0, 0, 0);

		// max dropped below the current level
		configure(1, 1, 4095, 0);
		send_pins(1, 0, 1);
		send_pins(0, 0, 1);
		send_pins(1, 0, 1);

		// step larger than the level
		configure(4095, 1000, 500, 80000);
		send_pins(0, 0, 1);
		send_pins(0, 1, 1);

		configure(1, 4095, 1, 0);
		run_phase(PHASE_ITEMS, 1'b0, -1);
		configure(4095, 1, 4095, 24'hFFFFFF);
		run_phase(PHASE_ITEMS, 1'b0, -1);
		configure(0, 1000, 0, 3);
		run_phase(PHASE_ITEMS, 1'b0, -1);
		configure($urandom_range(1, 300), $urandom_range(1, 4095),
			$urandom_range(1, 4095), $urandom_range(0, 20));
		run_phase(PHASE_ITEMS, 1'b1, -1);
		configure($urandom_range(1, 300), $urandom_range(1, 4095),
			$urandom_range(1, 4095), $urandom_range(0, 20));
		run_phase(PHASE_ITEMS, 1'b0, 100);
		configure($urandom_range(1, 4095), $urandom_range(1, 4095),
			$urandom_range(1, 4095), $urandom_range(0, 20));
		run_phase(PHASE_ITEMS, 1'b0, -1);

		wait_idle();
		repeat (8) @(posedge clk);

		$display("tb: %0d pin samples sent under %0d register settings, %0d results matched",
			sent, settings, matched);
		$display("tb: %0d encoder detents and %0d lamp toggles exercised", detents, toggles);
		if (errors == 0 && queued == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule
